// ===== rtl/kde_pkg.sv =====
// Shared types and constants for the key debounce / encoder emulator.
// No dependencies; used by every module under rtl/.
`default_nettype none

package kde_pkg;

  localparam int KEY_COUNT = 4;
  localparam int THR_W     = 8;
  localparam int LEVEL_W   = 10;
  localparam int TONE_W    = 12;
  localparam int STEP_W    = 2;
  localparam int IDX_W     = 2;

  // key positions inside the key vectors
  localparam int KEY_UP    = 0;
  localparam int KEY_DOWN  = 1;
  localparam int KEY_OK    = 2;
  localparam int KEY_LIGHT = 3;

  // item kinds carried in s_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [2:0] REG_LEVEL_OFF  = 3'd2;
  localparam logic [2:0] REG_LEVEL_LOW  = 3'd3;
  localparam logic [2:0] REG_LEVEL_MID  = 3'd4;
  localparam logic [2:0] REG_LEVEL_HIGH = 3'd5;

  localparam logic [THR_W-1:0]   DEBOUNCE_RST   = 8'd25;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF_RST  = 10'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW_RST  = 10'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_MID_RST  = 10'd614;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH_RST = 10'd1023;
  localparam logic [IDX_W-1:0]   LEVEL_IDX_RST  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_ZERO = 2'b00;
  localparam logic [STEP_W-1:0] STEP_POS  = 2'b01;
  localparam logic [STEP_W-1:0] STEP_NEG  = 2'b11;

  localparam logic [TONE_W-1:0] TONE_NONE  = 12'd0;
  localparam logic [TONE_W-1:0] TONE_UP    = 12'd1800;
  localparam logic [TONE_W-1:0] TONE_DOWN  = 12'd2000;
  localparam logic [TONE_W-1:0] TONE_OK    = 12'd2200;
  localparam logic [TONE_W-1:0] TONE_LIGHT = 12'd2400;

  typedef struct packed {
    logic                              enable;
    logic [THR_W-1:0]                  debounce_ticks;
    logic [KEY_COUNT-1:0][LEVEL_W-1:0] level;
  } cfg_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] press;
    logic [KEY_COUNT-1:0] rel;
  } key_evt_t;

  typedef struct packed {
    logic [TONE_W-1:0]  tone_hz;
    logic               backlight_changed;
    logic [LEVEL_W-1:0] backlight_value;
    logic               held;
    logic [STEP_W-1:0]  step_read;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/key_debounce_encoder_emulator.sv =====
// Channel   Dir  Payload
// s_*       in   tuser: op; tdata: up_raw, down_raw, ok_raw, light_raw (pins, 0 = pressed)
// m_*       out  tdata: step_read, held, backlight_value, backlight_changed, tone_hz
// apb       in   enable, debounce_ticks, level_off/low/mid/high at 0x00..0x14
//
// One item per cycle sustained while m_tready is high; a result passes the input register,
// then the result register, with the event logic between them, before it is presented.
// A stall on m_tready holds the result register; the input register keeps
// taking one more item, then s_tready drops until the result is taken.
// Reset (rst, synchronous) releases all keys, zeroes counters and step,
// clears held and sets the backlight index to 3; registers take reset values.
// Top level; depends on kde_pkg, kde_regs, kde_debounce, kde_events.
`default_nettype none

module key_debounce_encoder_emulator #(
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] up_raw, [1] down_raw, [2] ok_raw,
                                      // [3] light_raw, [7:4] zero
  input  wire logic        s_tuser,   // [0] op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [1:0] step_read, [2] held,
                                      // [12:3] backlight_value,
                                      // [13] backlight_changed,
                                      // [25:14] tone_hz, [31:26] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                          in_valid;
  logic                          in_op;
  logic [kde_pkg::KEY_COUNT-1:0] in_pressed;
  logic                          advance;
  logic                          tick;
  logic                          read;
  kde_pkg::cfg_t                 cfg;
  logic                          cfg_clear;
  kde_pkg::key_evt_t             evt;
  kde_pkg::res_t                 res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign tick     = advance && (in_op == kde_pkg::OP_TICK);
  assign read     = advance && (in_op == kde_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // pins are active low; store as pressed levels
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op      <= s_tuser;
      in_pressed <= ~s_tdata[kde_pkg::KEY_COUNT-1:0];
    end
  end

  kde_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  kde_debounce #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .raw_pressed    (in_pressed),
    .debounce_ticks (cfg.debounce_ticks),
    .evt            (evt)
  );

  kde_events u_events (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .read      (read),
    .evt       (evt),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, res};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kde_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on kde_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module kde_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output kde_pkg::cfg_t           cfg,
  output logic                    cfg_clear
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // writing enable low drops step and held flag in the event unit
  assign cfg_clear = wr_en && (reg_idx == kde_pkg::REG_ENABLE) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b1;
      cfg.debounce_ticks <= kde_pkg::DEBOUNCE_RST;
      cfg.level[0]       <= kde_pkg::LEVEL_OFF_RST;
      cfg.level[1]       <= kde_pkg::LEVEL_LOW_RST;
      cfg.level[2]       <= kde_pkg::LEVEL_MID_RST;
      cfg.level[3]       <= kde_pkg::LEVEL_HIGH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        kde_pkg::REG_ENABLE:     cfg.enable         <= pwdata[0];
        kde_pkg::REG_DEBOUNCE:   cfg.debounce_ticks <= pwdata[kde_pkg::THR_W-1:0];
        kde_pkg::REG_LEVEL_OFF:  cfg.level[0]       <= pwdata[kde_pkg::LEVEL_W-1:0];
        kde_pkg::REG_LEVEL_LOW:  cfg.level[1]       <= pwdata[kde_pkg::LEVEL_W-1:0];
        kde_pkg::REG_LEVEL_MID:  cfg.level[2]       <= pwdata[kde_pkg::LEVEL_W-1:0];
        kde_pkg::REG_LEVEL_HIGH: cfg.level[3]       <= pwdata[kde_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kde_pkg::REG_ENABLE:     prdata = {31'd0, cfg.enable};
      kde_pkg::REG_DEBOUNCE:   prdata = {24'd0, cfg.debounce_ticks};
      kde_pkg::REG_LEVEL_OFF:  prdata = {22'd0, cfg.level[0]};
      kde_pkg::REG_LEVEL_LOW:  prdata = {22'd0, cfg.level[1]};
      kde_pkg::REG_LEVEL_MID:  prdata = {22'd0, cfg.level[2]};
      kde_pkg::REG_LEVEL_HIGH: prdata = {22'd0, cfg.level[3]};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/kde_debounce.sv =====
// Per-key debounce lanes: raw level history, saturating tick counters and
// debounced levels. Depends on kde_pkg (KEY_COUNT, key_evt_t).
`default_nettype none

module kde_debounce #(
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tick,
  input  wire logic [kde_pkg::KEY_COUNT-1:0] raw_pressed,
  input  wire logic [kde_pkg::THR_W-1:0]     debounce_ticks,
  output kde_pkg::key_evt_t                  evt
);

  localparam int CMP_W = (COUNT_WIDTH > kde_pkg::THR_W) ? COUNT_WIDTH : kde_pkg::THR_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [kde_pkg::KEY_COUNT-1:0]                  last_raw;
  logic [kde_pkg::KEY_COUNT-1:0]                  stable;
  logic [kde_pkg::KEY_COUNT-1:0][COUNT_WIDTH-1:0] elapsed;
  logic [kde_pkg::KEY_COUNT-1:0]                  stable_next;
  logic [kde_pkg::KEY_COUNT-1:0][COUNT_WIDTH-1:0] elapsed_next;

  always_comb begin
    for (int k = 0; k < kde_pkg::KEY_COUNT; k++) begin
      if (raw_pressed[k] != last_raw[k]) begin
        elapsed_next[k] = '0;
      end else if (elapsed[k] != CNT_MAX) begin
        elapsed_next[k] = elapsed[k] + COUNT_WIDTH'(1);
      end else begin
        elapsed_next[k] = elapsed[k];
      end
      if (CMP_W'(elapsed_next[k]) >= CMP_W'(debounce_ticks)) begin
        stable_next[k] = raw_pressed[k];
      end else begin
        stable_next[k] = stable[k];
      end
    end
  end

  // edges of the debounced level; only meaningful on a tick
  assign evt.press = stable_next & ~stable;
  assign evt.rel   = ~stable_next & stable;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= '0;
      stable   <= '0;
      elapsed  <= '0;
    end else if (tick) begin
      last_raw <= raw_pressed;
      stable   <= stable_next;
      elapsed  <= elapsed_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kde_events.sv =====
// Event unit: step value, ok held flag, backlight level index and tone,
// and the result for the item in flight. Depends on kde_pkg.
`default_nettype none

module kde_events (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick,
  input  wire logic              read,
  input  wire kde_pkg::key_evt_t evt,
  input  wire kde_pkg::cfg_t     cfg,
  input  wire logic              cfg_clear,
  output kde_pkg::res_t          res
);

  logic [kde_pkg::STEP_W-1:0] step;
  logic                       held;
  logic [kde_pkg::IDX_W-1:0]  level_idx;
  logic [kde_pkg::STEP_W-1:0] step_next;
  logic                       held_next;
  logic [kde_pkg::IDX_W-1:0]  level_idx_next;
  logic                       changed;
  logic [kde_pkg::TONE_W-1:0] tone;

  always_comb begin
    step_next      = step;
    held_next      = held;
    level_idx_next = level_idx;
    changed        = 1'b0;
    tone           = kde_pkg::TONE_NONE;
    if (read) begin
      step_next = kde_pkg::STEP_ZERO;
    end else if (tick) begin
      // later keys override the tone of earlier ones
      if (cfg.enable && evt.press[kde_pkg::KEY_UP]) begin
        step_next = kde_pkg::STEP_NEG;
        tone      = kde_pkg::TONE_UP;
      end
      if (cfg.enable && evt.press[kde_pkg::KEY_DOWN]) begin
        step_next = kde_pkg::STEP_POS;
        tone      = kde_pkg::TONE_DOWN;
      end
      if (cfg.enable) begin
        if (evt.press[kde_pkg::KEY_OK]) begin
          held_next = 1'b1;
          tone      = kde_pkg::TONE_OK;
        end else if (evt.rel[kde_pkg::KEY_OK]) begin
          held_next = 1'b0;
        end
      end
      if (evt.press[kde_pkg::KEY_LIGHT]) begin
        level_idx_next = level_idx + kde_pkg::IDX_W'(1);
        changed        = 1'b1;
        tone           = kde_pkg::TONE_LIGHT;
      end
    end
  end

  assign res.step_read         = read ? step : kde_pkg::STEP_ZERO;
  assign res.held              = held_next & cfg.enable;
  assign res.backlight_value   = cfg.level[level_idx_next];
  assign res.backlight_changed = changed;
  assign res.tone_hz           = tone;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= kde_pkg::STEP_ZERO;
      held      <= 1'b0;
      level_idx <= kde_pkg::LEVEL_IDX_RST;
    end else if (cfg_clear) begin
      step <= kde_pkg::STEP_ZERO;
      held <= 1'b0;
    end else begin
      step      <= step_next;
      held      <= held_next;
      level_idx <= level_idx_next;
    end
  end

endmodule

`default_nettype wire
